// ===== sv/interleaved_bitplane_to_chunky_defines.svh =====
// ----------------------------------------------------------------------------
// Interleaved bitplane to chunky converter: assertion macros
// Concurrent check wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef INTERLEAVED_BITPLANE_TO_CHUNKY_DEFINES_SVH
`define INTERLEAVED_BITPLANE_TO_CHUNKY_DEFINES_SVH

`ifndef SYNTH
// check that is masked while reset is high
`define IBC_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check that also runs through reset
`define IBC_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IBC_ASSERT(name, clk, rst, prop, msg)
`define IBC_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// ===== sv/ibc_pkg.sv =====
// ----------------------------------------------------------------------------
// Interleaved bitplane to chunky converter: package
// Shared widths, register and mode codes, and the group record type.
// ----------------------------------------------------------------------------
package ibc_pkg;

   localparam int WORD_WIDTH      = 16;
   localparam int PIXEL_WIDTH     = 4;
   localparam int PLANES_MAX      = 4;
   localparam int HELD_WORDS      = 3;
   localparam int GROUP_WIDTH     = 6;
   localparam int COUNT_WIDTH     = 4;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 6;
   localparam int QUEUE_DEPTH     = 2;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RESOLUTION_MODE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ROW_GROUPS      = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MONO_INVERT     = 2'd2;

   // resolution mode codes
   localparam logic [1:0] MODE_FOUR_PLANES = 2'd0;
   localparam logic [1:0] MODE_TWO_PLANES  = 2'd1;
   localparam logic [1:0] MODE_MONO        = 2'd2;
   localparam logic [1:0] MODE_UNUSED      = 2'd3;

   localparam logic [GROUP_WIDTH-1:0] ROW_GROUPS_RESET = 6'd20;
   localparam logic [COUNT_WIDTH-1:0] LAST_PIXEL       = 4'd15;

   typedef struct packed {
      logic [1:0]             resolution_mode;
      logic [GROUP_WIDTH-1:0] row_groups;
      logic                   mono_invert;
   } cfg_type;

   // one finished group: plane words, unused planes zero, invert applied
   typedef struct packed {
      logic [PLANES_MAX-1:0][WORD_WIDTH-1:0] planes;
      logic                                  row_end;
   } group_type;

endpackage

// ===== sv/ibc_front.sv =====
// ----------------------------------------------------------------------------
// Interleaved bitplane to chunky converter: front end
// Collects plane words of a group and hands a finished group record
// to the queue, tracking the group position within the row.
// ----------------------------------------------------------------------------
module ibc_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [ibc_pkg::WORD_WIDTH-1:0]  req_data_word,
   input  ibc_pkg::cfg_type                cfg,
   input  logic                            queue_full,
   output logic                            queue_push,
   output ibc_pkg::group_type              queue_data
);

   logic [ibc_pkg::WORD_WIDTH-1:0]  held_ff [ibc_pkg::HELD_WORDS];
   logic [1:0]                      plane_cnt_ff, plane_cnt_in;
   logic [ibc_pkg::GROUP_WIDTH-1:0] group_cnt_ff, group_cnt_in;

   logic                            accept;
   logic                            mode_valid;
   logic [1:0]                      planes_m1;
   logic                            last_word;
   logic [ibc_pkg::GROUP_WIDTH-1:0] next_group;
   logic                            row_end;

   // plane count from mode
   always_comb begin
      mode_valid = 1'b1;
      planes_m1  = 2'd0;
      case (cfg.resolution_mode)
         ibc_pkg::MODE_FOUR_PLANES: planes_m1 = 2'd3;
         ibc_pkg::MODE_TWO_PLANES:  planes_m1 = 2'd1;
         ibc_pkg::MODE_MONO:        planes_m1 = 2'd0;
         default:                   mode_valid = 1'b0;
      endcase
   end

   assign req_full   = queue_full;
   assign accept     = req_push && !queue_full;
   assign last_word  = plane_cnt_ff >= planes_m1;
   assign next_group = group_cnt_ff + 6'd1;
   assign row_end    = next_group == cfg.row_groups;
   assign queue_push = accept && mode_valid && last_word;

   // group record: held words plus the incoming last word
   always_comb begin
      queue_data.row_end = row_end;
      queue_data.planes  = '0;
      case (planes_m1)
         2'd0: queue_data.planes[0] = req_data_word ^ {ibc_pkg::WORD_WIDTH{cfg.mono_invert}};
         2'd1: begin
            queue_data.planes[0] = held_ff[0];
            queue_data.planes[1] = req_data_word;
         end
         2'd3: begin
            queue_data.planes[0] = held_ff[0];
            queue_data.planes[1] = held_ff[1];
            queue_data.planes[2] = held_ff[2];
            queue_data.planes[3] = req_data_word;
         end
         default: queue_data.planes = '0;
      endcase
   end

   // counters
   always_comb begin
      plane_cnt_in = plane_cnt_ff;
      group_cnt_in = group_cnt_ff;
      if (accept && mode_valid) begin
         if (last_word) begin
            plane_cnt_in = 2'd0;
            group_cnt_in = row_end ? '0 : next_group;
         end else begin
            plane_cnt_in = plane_cnt_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_cnt_ff <= 2'd0;
         group_cnt_ff <= '0;
      end else begin
         plane_cnt_ff <= plane_cnt_in;
         group_cnt_ff <= group_cnt_in;
      end
   end

   // plane word store, no reset
   always_ff @(posedge clock) begin
      if (accept && mode_valid && !last_word) begin
         held_ff[plane_cnt_ff] <= req_data_word;
      end
   end

endmodule

// ===== sv/ibc_queue.sv =====
// ----------------------------------------------------------------------------
// Interleaved bitplane to chunky converter: group queue
// Short register FIFO of group records between front and back end.
// ----------------------------------------------------------------------------
module ibc_queue #(
   parameter int DEPTH = ibc_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ibc_pkg::group_type push_data,
   output logic               full,
   input  logic               pop,
   output ibc_pkg::group_type pop_data,
   output logic               empty
);

   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] PTR_LAST = PTR_WIDTH'(DEPTH - 1);
   localparam logic [CNT_WIDTH-1:0] CNT_FULL = CNT_WIDTH'(DEPTH);

   ibc_pkg::group_type    entry_ff [DEPTH];
   logic [PTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]  count_ff, count_in;
   logic                  do_push, do_pop;

   assign full     = count_ff == CNT_FULL;
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/ibc_back.sv =====
// ----------------------------------------------------------------------------
// Interleaved bitplane to chunky converter: back end
// Loads a group record and shifts out one pixel index per beat,
// leftmost pixel first, with group and row end flags.
// ----------------------------------------------------------------------------
module ibc_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             queue_empty,
   input  ibc_pkg::group_type               queue_data,
   output logic                             queue_pop,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [ibc_pkg::PIXEL_WIDTH-1:0]  rsp_pixel_index,
   output logic                             rsp_group_last,
   output logic                             rsp_row_last
);

   logic                                                  busy_ff, busy_in;
   logic [ibc_pkg::COUNT_WIDTH-1:0]                       count_ff, count_in;
   logic [ibc_pkg::PLANES_MAX-1:0][ibc_pkg::WORD_WIDTH-1:0] plane_ff, plane_in;
   logic                                                  row_end_ff, row_end_in;
   logic                                                  beat, last_pixel, load;

   assign last_pixel = count_ff == ibc_pkg::LAST_PIXEL;
   assign beat       = busy_ff && rsp_pop;
   assign load       = (!busy_ff || (beat && last_pixel)) && !queue_empty;
   assign queue_pop  = load;

   // current pixel from the top bit of each plane
   always_comb begin
      for (int p = 0; p < ibc_pkg::PLANES_MAX; p++) begin
         rsp_pixel_index[p] = plane_ff[p][ibc_pkg::WORD_WIDTH-1];
      end
   end

   assign rsp_empty      = !busy_ff;
   assign rsp_group_last = last_pixel;
   assign rsp_row_last   = last_pixel && row_end_ff;

   // shift and load
   always_comb begin
      busy_in    = busy_ff;
      count_in   = count_ff;
      plane_in   = plane_ff;
      row_end_in = row_end_ff;
      if (beat) begin
         count_in = count_ff + 1'b1;
         for (int p = 0; p < ibc_pkg::PLANES_MAX; p++) begin
            plane_in[p] = {plane_ff[p][ibc_pkg::WORD_WIDTH-2:0], 1'b0};
         end
         if (last_pixel) begin
            busy_in = 1'b0;
         end
      end
      if (load) begin
         busy_in    = 1'b1;
         count_in   = '0;
         plane_in   = queue_data.planes;
         row_end_in = queue_data.row_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      plane_ff   <= plane_in;
      row_end_ff <= row_end_in;
   end

endmodule

// ===== sv/interleaved_bitplane_to_chunky.sv =====
// ----------------------------------------------------------------------------
// Load path: a group record is registered in the queue as its last plane word
//   is taken; an idle shifter then loads it, and its first pixel is poppable.
// Throughput: one pixel per cycle from the output shifter while rsp_pop is
//   held; plane words are taken every cycle while the group queue has room.
// Reset: synchronous, active high; clears counters, queue and config to
//   defaults (four planes, 20 groups per row, no invert).
// ----------------------------------------------------------------------------
`include "interleaved_bitplane_to_chunky_defines.svh"

module interleaved_bitplane_to_chunky #(
   parameter int QUEUE_DEPTH = ibc_pkg::QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [ibc_pkg::WORD_WIDTH-1:0]       req_data_word,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic [ibc_pkg::PIXEL_WIDTH-1:0]      rsp_pixel_index,
   output logic                                 rsp_group_last,
   output logic                                 rsp_row_last,
   input  logic                                 csr_write_en,
   input  logic [ibc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [ibc_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);

   ibc_pkg::cfg_type   cfg_ff, cfg_in;
   ibc_pkg::group_type push_data, pop_data;
   logic               q_push, q_full, q_pop, q_empty;
   logic               group_waiting, drain_beat;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            ibc_pkg::REG_RESOLUTION_MODE: cfg_in.resolution_mode = csr_data[1:0];
            ibc_pkg::REG_ROW_GROUPS:      cfg_in.row_groups      = csr_data;
            ibc_pkg::REG_MONO_INVERT:     cfg_in.mono_invert     = csr_data[0];
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.resolution_mode <= ibc_pkg::MODE_FOUR_PLANES;
         cfg_ff.row_groups      <= ibc_pkg::ROW_GROUPS_RESET;
         cfg_ff.mono_invert     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ibc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_data_word (req_data_word),
      .cfg           (cfg_ff),
      .queue_full    (q_full),
      .queue_push    (q_push),
      .queue_data    (push_data)
   );

   ibc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   ibc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_empty     (q_empty),
      .queue_data      (pop_data),
      .queue_pop       (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_group_last  (rsp_group_last),
      .rsp_row_last    (rsp_row_last)
   );

   // check terms
   assign group_waiting = rsp_empty && !q_empty;
   assign drain_beat    = !rsp_empty && rsp_pop && rsp_group_last && q_empty;

   // checks
   `IBC_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> rsp_empty, "output not empty after reset")
   `IBC_ASSERT(a_idle_loads, clock, reset, group_waiting |=> !rsp_empty, "queued group not loaded")
   `IBC_ASSERT(a_drain_empty, clock, reset, drain_beat |=> rsp_empty, "busy with no group")

endmodule
